// ----- hdl/binary_lifting_lca_engine_macros.svh -----
// Assertion macros used by the lowest-common-ancestor engine datapath.
`ifndef BINARY_LIFTING_LCA_ENGINE_MACROS_SVH
`define BINARY_LIFTING_LCA_ENGINE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BLCA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BLCA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/blca_pkg.sv -----
// Shared constants, types and datapath command codes of the LCA engine.
package blca_pkg;

    localparam int NODES    = 1024;
    localparam int LEVELS   = 10;
    localparam int NODE_W   = $clog2(NODES);
    localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DEPTH_W  = 10;
    localparam int CNT_W    = 11;
    localparam int PATH_W   = 11;
    localparam int KIND_W   = 2;
    localparam int JT_DEPTH = LEVELS * NODES;
    localparam int JT_AW    = LVL_W + NODE_W;

    // Request codes, echoed as result codes.
    localparam logic [KIND_W-1:0] REQ_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] REQ_BUILD   = 2'd1;
    localparam logic [KIND_W-1:0] REQ_QUERY   = 2'd2;
    // Unused code; such a request is dropped without a result.
    localparam logic [KIND_W-1:0] REQ_UNKNOWN = 2'd3;

    // Commands from the controller to the datapath.
    typedef enum logic [4:0] {
        OP_NONE, OP_CAP, OP_LOAD,
        OP_B_RD1, OP_B_RD2, OP_B_WR, OP_B_DONE,
        OP_Q_RDA, OP_Q_RDB, OP_Q_ORD,
        OP_L_RDJ, OP_L_RDD, OP_L_UPD, OP_EQ,
        OP_C_RDU, OP_C_RDV, OP_C_UPD,
        OP_A_RD, OP_A_DEP, OP_A_CAP, OP_FIN
    } t_dp_op;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              q_ok;
        logic              lvl_zero;
        logic              lvl_last;
        logic              node_last;
        logic              u_eq_v;
        logic              out_free;
    } t_dp_status;

endpackage

// ----- hdl/blca_req_if.sv -----
// Request channel interface of the LCA engine.
interface blca_req_if;
    import blca_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   req_type;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [DEPTH_W-1:0]  node_depth_in;

    modport source (output valid, req_type, node_a, node_b, node_depth_in, input ready);
    modport sink   (input valid, req_type, node_a, node_b, node_depth_in, output ready);
endinterface

// ----- hdl/blca_rsp_if.sv -----
// Result channel interface of the LCA engine.
interface blca_rsp_if;
    import blca_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   result_kind;
    logic [NODE_W-1:0]   ancestor;
    logic [PATH_W-1:0]   path_nodes;

    modport source (output valid, result_kind, ancestor, path_nodes, input ready);
    modport sink   (input valid, result_kind, ancestor, path_nodes, output ready);
endinterface

// ----- hdl/blca_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module blca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/blca_ctrl.sv -----
// Controller state machine that sequences loads, builds and queries.
module blca_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  blca_pkg::t_dp_status i_status,
    output blca_pkg::t_dp_op    o_op
);
    import blca_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_LOAD,
        S_B_RD1, S_B_RD2, S_B_WR, S_B_DONE,
        S_Q_RDA, S_Q_RDB, S_Q_ORD,
        S_L_RDJ, S_L_RDD, S_L_UPD, S_EQ,
        S_C_RDU, S_C_RDV, S_C_UPD,
        S_A_RD, S_A_DEP, S_A_CAP, S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == S_IDLE);

    // Command issued in each state.
    always_comb begin
        case (r_state)
            S_IDLE:   o_op = i_req_valid ? OP_CAP : OP_NONE;
            S_DISP:   o_op = OP_NONE;
            S_LOAD:   o_op = OP_LOAD;
            S_B_RD1:  o_op = OP_B_RD1;
            S_B_RD2:  o_op = OP_B_RD2;
            S_B_WR:   o_op = OP_B_WR;
            S_B_DONE: o_op = OP_B_DONE;
            S_Q_RDA:  o_op = OP_Q_RDA;
            S_Q_RDB:  o_op = OP_Q_RDB;
            S_Q_ORD:  o_op = OP_Q_ORD;
            S_L_RDJ:  o_op = OP_L_RDJ;
            S_L_RDD:  o_op = OP_L_RDD;
            S_L_UPD:  o_op = OP_L_UPD;
            S_EQ:     o_op = OP_EQ;
            S_C_RDU:  o_op = OP_C_RDU;
            S_C_RDV:  o_op = OP_C_RDV;
            S_C_UPD:  o_op = OP_C_UPD;
            S_A_RD:   o_op = OP_A_RD;
            S_A_DEP:  o_op = OP_A_DEP;
            S_A_CAP:  o_op = OP_A_CAP;
            S_FIN:    o_op = OP_FIN;
            default:  o_op = OP_NONE;
        endcase
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_req_valid) n_state = S_DISP;
            S_DISP: begin
                case (i_status.kind)
                    REQ_LOAD:  n_state = S_LOAD;
                    REQ_BUILD: n_state = (LEVELS > 1) ? S_B_RD1 : S_B_DONE;
                    REQ_QUERY: n_state = i_status.q_ok ? S_Q_RDA : S_FIN;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_LOAD:   n_state = S_FIN;
            S_B_RD1:  n_state = S_B_RD2;
            S_B_RD2:  n_state = S_B_WR;
            S_B_WR: begin
                n_state = (i_status.node_last && i_status.lvl_last) ? S_B_DONE : S_B_RD1;
            end
            S_B_DONE: n_state = S_FIN;
            S_Q_RDA:  n_state = S_Q_RDB;
            S_Q_RDB:  n_state = S_Q_ORD;
            S_Q_ORD:  n_state = S_L_RDJ;
            S_L_RDJ:  n_state = S_L_RDD;
            S_L_RDD:  n_state = S_L_UPD;
            S_L_UPD:  n_state = i_status.lvl_zero ? S_EQ : S_L_RDJ;
            S_EQ:     n_state = i_status.u_eq_v ? S_FIN : S_C_RDU;
            S_C_RDU:  n_state = S_C_RDV;
            S_C_RDV:  n_state = S_C_UPD;
            S_C_UPD:  n_state = i_status.lvl_zero ? S_A_RD : S_C_RDU;
            S_A_RD:   n_state = S_A_DEP;
            S_A_DEP:  n_state = S_A_CAP;
            S_A_CAP:  n_state = S_FIN;
            S_FIN:    if (i_status.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ----- hdl/blca_dp.sv -----
// Datapath of the LCA engine: jump table, depth store and query registers.
`include "binary_lifting_lca_engine_macros.svh"
module blca_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [blca_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic [blca_pkg::KIND_W-1:0] i_req_type,
    input  logic [blca_pkg::NODE_W-1:0] i_node_a,
    input  logic [blca_pkg::NODE_W-1:0] i_node_b,
    input  logic [blca_pkg::DEPTH_W-1:0] i_node_depth_in,
    input  blca_pkg::t_dp_op            i_op,
    output blca_pkg::t_dp_status        o_status,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [blca_pkg::KIND_W-1:0] o_result_kind,
    output logic [blca_pkg::NODE_W-1:0] o_ancestor,
    output logic [blca_pkg::PATH_W-1:0] o_path_nodes
);
    import blca_pkg::*;

    localparam int PW = PATH_W + 2;

    logic [CNT_W-1:0]   r_node_count;
    logic               r_built;
    logic [KIND_W-1:0]  r_kind;
    logic [NODE_W-1:0]  r_a, r_b, r_u, r_v, r_tmp, r_anc, r_node;
    logic [DEPTH_W-1:0] r_d, r_du, r_dv, r_danc;
    logic [DEPTH_W:0]   r_sum;
    logic [LVL_W-1:0]   r_lvl;
    logic               r_qok;
    logic               r_o_valid;
    logic [KIND_W-1:0]  r_o_kind;
    logic [NODE_W-1:0]  r_o_anc;
    logic [PATH_W-1:0]  r_o_path;

    logic [CNT_W-1:0]   cnt;
    logic               out_free;
    logic               jt_we, dp_we;
    logic [JT_AW-1:0]   jt_waddr, jt_raddr;
    logic [NODE_W-1:0]  jt_wdata, jt_rd, dp_waddr, dp_raddr;
    logic [DEPTH_W-1:0] dp_wdata, dp_rd;
    logic signed [PW-1:0] path_full;
    logic [PATH_W-1:0]  path_sat;

    // Node count in use, saturated to 1 .. NODES.
    always_comb begin
        if (r_node_count == '0) begin
            cnt = CNT_W'(1);
        end else if (r_node_count > CNT_W'(NODES)) begin
            cnt = CNT_W'(NODES);
        end else begin
            cnt = r_node_count;
        end
    end

    assign out_free = !r_o_valid || i_ready;

    // Memory address and write control for each command.
    always_comb begin
        jt_we    = 1'b0;
        jt_waddr = {r_lvl, r_node};
        jt_wdata = jt_rd;
        jt_raddr = '0;
        dp_we    = 1'b0;
        dp_waddr = r_a;
        dp_wdata = r_d;
        dp_raddr = '0;
        case (i_op)
            OP_LOAD: begin
                // The parent index always lies below NODES at this width.
                jt_we    = ({1'b0, r_a} < cnt);
                jt_waddr = {LVL_W'(0), r_a};
                jt_wdata = r_b;
                dp_we    = ({1'b0, r_a} < cnt);
            end
            OP_B_RD1: jt_raddr = {r_lvl - LVL_W'(1), r_node};
            OP_B_RD2: jt_raddr = {r_lvl - LVL_W'(1), jt_rd};
            OP_B_WR:  jt_we    = 1'b1;
            OP_Q_RDA: dp_raddr = r_a;
            OP_Q_RDB: dp_raddr = r_b;
            OP_L_RDJ: jt_raddr = {r_lvl, r_u};
            OP_L_RDD: dp_raddr = jt_rd;
            OP_C_RDU: jt_raddr = {r_lvl, r_u};
            OP_C_RDV: jt_raddr = {r_lvl, r_v};
            OP_A_RD:  jt_raddr = {LVL_W'(0), r_u};
            OP_A_DEP: dp_raddr = jt_rd;
            default: begin
            end
        endcase
    end

    blca_ram #(.WIDTH(NODE_W), .DEPTH(JT_DEPTH)) u_jump_ram (
        .i_clk   (i_clk),
        .i_we    (jt_we),
        .i_waddr (jt_waddr),
        .i_wdata (jt_wdata),
        .i_raddr (jt_raddr),
        .o_rdata (jt_rd)
    );

    blca_ram #(.WIDTH(DEPTH_W), .DEPTH(NODES)) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (dp_we),
        .i_waddr (dp_waddr),
        .i_wdata (dp_wdata),
        .i_raddr (dp_raddr),
        .o_rdata (dp_rd)
    );

    // Path node count: depth_a + depth_b - 2 * depth_lca + 1, clamped.
    assign path_full = $signed({2'b00, r_sum}) + PW'(1) - $signed({2'b00, r_danc, 1'b0});
    always_comb begin
        if (path_full < 0) begin
            path_sat = '0;
        end else if (path_full > PW'(2047)) begin
            path_sat = PATH_W'(2047);
        end else begin
            path_sat = path_full[PATH_W-1:0];
        end
    end

    // Control registers: count, built flag, level counter, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_W'(1024);
            r_built      <= 1'b0;
            r_lvl        <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
                r_built      <= 1'b0;
            end else if (i_op == OP_B_DONE) begin
                r_built <= 1'b1;
            end
            // A new result may replace one that drains in the same cycle.
            if (i_op == OP_FIN && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (i_op)
                OP_CAP:   r_lvl <= LVL_W'((LEVELS > 1) ? 1 : 0);
                OP_B_WR: begin
                    if (o_status.node_last && !o_status.lvl_last) begin
                        r_lvl <= r_lvl + LVL_W'(1);
                    end
                end
                OP_Q_ORD: r_lvl <= LVL_W'(LEVELS - 1);
                OP_EQ:    r_lvl <= LVL_W'(LEVELS - 1);
                OP_L_UPD, OP_C_UPD: begin
                    if (r_lvl != '0) begin
                        r_lvl <= r_lvl - LVL_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers of the current item.
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_CAP: begin
                r_kind <= i_req_type;
                r_a    <= i_node_a;
                r_b    <= i_node_b;
                r_d    <= i_node_depth_in;
                r_node <= '0;
                r_qok  <= r_built && ({1'b0, i_node_a} < cnt) && ({1'b0, i_node_b} < cnt);
            end
            OP_B_WR: begin
                r_node <= o_status.node_last ? '0 : r_node + NODE_W'(1);
            end
            OP_Q_RDB: r_du <= dp_rd;
            OP_Q_ORD: begin
                // Put the deeper node in u.
                r_sum <= {1'b0, r_du} + {1'b0, dp_rd};
                if (r_du < dp_rd) begin
                    r_u  <= r_b;
                    r_du <= dp_rd;
                    r_v  <= r_a;
                    r_dv <= r_du;
                end else begin
                    r_u  <= r_a;
                    r_v  <= r_b;
                    r_dv <= dp_rd;
                end
            end
            OP_L_RDD: r_tmp <= jt_rd;
            OP_L_UPD: begin
                if (dp_rd >= r_dv) begin
                    r_u  <= r_tmp;
                    r_du <= dp_rd;
                end
            end
            OP_EQ: begin
                r_anc  <= r_u;
                r_danc <= r_du;
            end
            OP_C_RDV: r_tmp <= jt_rd;
            OP_C_UPD: begin
                if (r_tmp != jt_rd) begin
                    r_u <= r_tmp;
                    r_v <= jt_rd;
                end
            end
            OP_A_DEP: r_anc  <= jt_rd;
            OP_A_CAP: r_danc <= dp_rd;
            OP_FIN: begin
                if (out_free) begin
                    r_o_kind <= r_kind;
                    if (r_kind == REQ_QUERY && r_qok) begin
                        r_o_anc  <= r_anc;
                        r_o_path <= path_sat;
                    end else begin
                        r_o_anc  <= '0;
                        r_o_path <= '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Status toward the controller.
    assign o_status.kind      = r_kind;
    assign o_status.q_ok      = r_qok;
    assign o_status.lvl_zero  = (r_lvl == '0);
    assign o_status.lvl_last  = (r_lvl == LVL_W'(LEVELS - 1));
    assign o_status.node_last = ({1'b0, r_node} == cnt - CNT_W'(1));
    assign o_status.u_eq_v    = (r_u == r_v);
    assign o_status.out_free  = out_free;

    assign o_valid       = r_o_valid;
    assign o_result_kind = r_o_kind;
    assign o_ancestor    = r_o_anc;
    assign o_path_nodes  = r_o_path;

    `BLCA_ASSERT_IMP(a_kind_known, r_o_valid, r_o_kind != REQ_UNKNOWN, "result with unknown kind")
    `BLCA_ASSERT_IMP(a_zero_fields, r_o_valid && r_o_kind != REQ_QUERY, r_o_anc == '0 && r_o_path == '0, "non-query result carries data")
    `BLCA_ASSERT_NXT(a_cfg_clears, i_cfg_we, !r_built, "count write left table marked built")
    `BLCA_ASSERT_IMP(a_lvl_range, 1'b1, r_lvl <= LVL_W'(LEVELS - 1), "level counter out of range")
endmodule

// ----- hdl/binary_lifting_lca_engine.sv -----
// Top level of the binary-lifting lowest-common-ancestor engine.
//
// Requests arrive on i_req (valid/ready) and results leave on o_rsp
// (valid/ready); an item moves when valid and ready are both high.
// A load writes parent and depth of node a if a < node_count, and is answered.
// A build fills jump-table levels 1 .. LEVELS-1 for every node in use; each
// entry takes two dependent reads on the single jump-table read port (states
// B_RD1, B_RD2) and then a write (B_WR).
// A query reads both depths and lifts the deeper node level by level from
// LEVELS-1 down to 0; when one node is an ancestor of the other it ends there,
// else it climbs both nodes and then reads the parent of u and its depth.
// One item is worked on at a time; i_req.ready is high while the engine idles.
// Results sit in an output register; while the receiver stalls, a finished
// item holds there and the engine waits with the next result until it drains.
// Reset clears the built flag, sets node_count to 1024 and empties the output;
// the jump-table and depth RAMs are not cleared and must be loaded first. The
// user writes node_count via i_cfg_we / i_cfg_wdata while idle; not enforced.
module binary_lifting_lca_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [blca_pkg::CNT_W-1:0] i_cfg_wdata,
    blca_req_if.sink                   i_req,
    blca_rsp_if.source                 o_rsp
);
    import blca_pkg::*;

    t_dp_op     op;
    t_dp_status status;

    blca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_op        (op)
    );

    blca_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_type      (i_req.req_type),
        .i_node_a        (i_req.node_a),
        .i_node_b        (i_req.node_b),
        .i_node_depth_in (i_req.node_depth_in),
        .i_op            (op),
        .o_status        (status),
        .o_valid         (o_rsp.valid),
        .i_ready         (o_rsp.ready),
        .o_result_kind   (o_rsp.result_kind),
        .o_ancestor      (o_rsp.ancestor),
        .o_path_nodes    (o_rsp.path_nodes)
    );
endmodule
